>>> rtl/asa_pkg.sv
// Shared types and constants for the shelf allocator.
// No dependencies; every other file imports this package.
`default_nettype none
package asa_pkg;

  localparam int MAX_PAGES     = 8;
  localparam int COORD_BITS    = 12;
  localparam int FIELD_BITS    = 12;
  localparam int PAGE_IDX_BITS = 3;
  localparam int CFG_IDX_BITS  = 1;

  localparam int PAGE_BITS     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int PAGE_CNT_BITS = $clog2(MAX_PAGES + 1);
  localparam int SUM_BITS      = ((COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS) + 2;

  localparam int START_POS  = 1;
  localparam int RESET_SIZE = 128;

  localparam logic [CFG_IDX_BITS-1:0] REG_ATLAS_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_ATLAS_HEIGHT = CFG_IDX_BITS'(1);

  typedef enum logic [1:0] {
    STAT_PLACED  = 2'd0,
    STAT_TOO_BIG = 2'd1,
    STAT_NO_PAGE = 2'd2
  } alloc_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_PLACE,
    S_EMIT
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;
    logic clr_scan;
    logic inc_scan;
    logic sel_scan;
    logic open_new;
    logic place;
    logic err_big;
    logic err_full;
    logic out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic too_big;
    logic scan_end;
    logic fits;
    logic full;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

>>> rtl/asa_req_if.sv
// Request channel: rectangle size with valid/ready.
// Depends on asa_pkg.
`default_nettype none
interface asa_req_if import asa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] req_width;
  logic [FIELD_BITS-1:0] req_height;

  modport source (output valid, req_width, req_height, input ready);
  modport sink   (input valid, req_width, req_height, output ready);
endinterface
`default_nettype wire

>>> rtl/asa_res_if.sv
// Result channel: placement of one rectangle with valid/ready.
// Depends on asa_pkg.
`default_nettype none
interface asa_res_if import asa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [PAGE_IDX_BITS-1:0] page_index;
  logic [FIELD_BITS-1:0]    pos_x;
  logic [FIELD_BITS-1:0]    pos_y;
  logic                     opened_page;
  logic [1:0]               status;

  modport source (output valid, page_index, pos_x, pos_y, opened_page, status, input ready);
  modport sink   (input valid, page_index, pos_x, pos_y, opened_page, status, output ready);
endinterface
`default_nettype wire

>>> rtl/asa_cfg_if.sv
// Configuration write channel: register index and data with valid/ready.
// Depends on asa_pkg.
`default_nettype none
interface asa_cfg_if import asa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] reg_index;
  logic [FIELD_BITS-1:0]   wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface
`default_nettype wire

>>> rtl/atlas_shelf_allocator.sv
// Top level of the shelf allocator: controller plus datapath.
// Depends on asa_pkg, the channel interfaces, asa_ctrl and asa_dpath.
//
// Usage notes
//  - in_ch carries one request (req_width, req_height) per transaction.
//    in_ready is high only while the block is idle, so one request is
//    in flight at a time.
//  - out_ch returns exactly one result per request: page_index, pos_x,
//    pos_y, opened_page and status (placed, larger than a page, no page
//    left). On an error the other fields read zero and nothing changes.
//  - cfg_ch writes atlas_width (index 0) or atlas_height (index 1). It is
//    always ready; write only while no request is outstanding.
//  - A request passes through S_CHECK; an oversize one goes on to S_EMIT,
//    any other through S_SCAN, S_PLACE (skipped when no page is left) and
//    S_EMIT. The page scan, one page per cycle through the cursor register
//    file, tests the open pages and stops at the first one that fits.
//  - A new request is taken the cycle after the result is loaded, even if
//    the receiver has not yet taken it: the output register holds it.
//  - If out_ready stays low the result waits in the output register; a
//    following result then waits in the datapath until the slot frees.
//  - Reset (rst_n low, synchronous) closes all pages and sets both page
//    dimensions to 128 texels.
`default_nettype none
module atlas_shelf_allocator import asa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  asa_req_if.sink   in_ch,
  asa_res_if.source out_ch,
  asa_cfg_if.sink   cfg_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // controller owns request acceptance
  asa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath owns the page state, size registers and result register
  asa_dpath u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule
`default_nettype wire

>>> rtl/asa_ctrl.sv
// Sequencer for the allocator: check, page scan, placement, result hand-off.
// Depends on asa_pkg; drives the datapath through dp_cmd_t.
`default_nettype none
module asa_ctrl import asa_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.too_big) begin
          cmd.err_big = 1'b1;
          state_nxt   = S_EMIT;
        end else begin
          cmd.clr_scan = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          if (sts.full) begin
            cmd.err_full = 1'b1;
            state_nxt    = S_EMIT;
          end else begin
            cmd.open_new = 1'b1;
            state_nxt    = S_PLACE;
          end
        end else if (sts.fits) begin
          cmd.sel_scan = 1'b1;
          state_nxt    = S_PLACE;
        end else begin
          cmd.inc_scan = 1'b1;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/asa_dpath.sv
// Datapath: size registers, per-page cursor file, fit test, placement, output register.
// Depends on asa_pkg and the channel interfaces.
`default_nettype none
module asa_dpath import asa_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  asa_req_if.sink      in_ch,
  asa_res_if.source    out_ch,
  asa_cfg_if.sink      cfg_ch,
  input  wire dp_cmd_t cmd,
  output dp_sts_t      sts
);

  logic [FIELD_BITS-1:0]    aw_r, ah_r;
  logic [FIELD_BITS-1:0]    w_r, h_r;
  logic [PAGE_CNT_BITS-1:0] pages_open_r;
  logic [PAGE_CNT_BITS-1:0] scan_r;
  logic [PAGE_BITS-1:0]     sel_r;
  logic                     opened_r;

  logic [COORD_BITS-1:0] cx_mem [MAX_PAGES];
  logic [COORD_BITS-1:0] cy_mem [MAX_PAGES];
  logic [COORD_BITS-1:0] rh_mem [MAX_PAGES];

  logic [PAGE_IDX_BITS-1:0] res_page_r;
  logic [FIELD_BITS-1:0]    res_x_r, res_y_r;
  logic                     res_opened_r;
  alloc_status_t            res_status_r;

  logic                     out_valid_r;
  logic [PAGE_IDX_BITS-1:0] out_page_r;
  logic [FIELD_BITS-1:0]    out_x_r, out_y_r;
  logic                     out_opened_r;
  alloc_status_t            out_status_r;

  logic [SUM_BITS-1:0] aw_s, ah_s, w_s, h_s;

  assign aw_s = SUM_BITS'(aw_r);
  assign ah_s = SUM_BITS'(ah_r);
  assign w_s  = SUM_BITS'(w_r);
  assign h_s  = SUM_BITS'(h_r);

  // config writes, always accepted
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r <= FIELD_BITS'(RESET_SIZE);
      ah_r <= FIELD_BITS'(RESET_SIZE);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        REG_ATLAS_WIDTH:  aw_r <= cfg_ch.wr_data;
        REG_ATLAS_HEIGHT: ah_r <= cfg_ch.wr_data;
        default: ;
      endcase
    end
  end

  // fit test on the page under the scan index
  logic [COORD_BITS-1:0] scx, scy, srh;
  logic                  row_over;

  assign scx      = cx_mem[scan_r[PAGE_BITS-1:0]];
  assign scy      = cy_mem[scan_r[PAGE_BITS-1:0]];
  assign srh      = rh_mem[scan_r[PAGE_BITS-1:0]];
  assign row_over = (SUM_BITS'(scx) + w_s) > aw_s;

  assign sts.fits = !(row_over && ((SUM_BITS'(scy) + SUM_BITS'(srh) + h_s) > ah_s))
                    && !((SUM_BITS'(scy) + h_s) > ah_s);
  assign sts.too_big  = ((w_s + SUM_BITS'(START_POS)) > aw_s)
                     || ((h_s + SUM_BITS'(START_POS)) > ah_s);
  assign sts.scan_end = (scan_r == pages_open_r);
  assign sts.full     = (pages_open_r == PAGE_CNT_BITS'(MAX_PAGES));
  assign sts.out_free = !out_valid_r || out_ch.ready;

  // placement on the selected page; a fresh page starts at (START_POS, START_POS)
  logic [COORD_BITS-1:0] bcx, bcy, brh;
  logic [COORD_BITS-1:0] ncx, ncy, nrh, rh_upd;
  logic                  wrap;

  assign bcx  = opened_r ? COORD_BITS'(START_POS) : cx_mem[sel_r];
  assign bcy  = opened_r ? COORD_BITS'(START_POS) : cy_mem[sel_r];
  assign brh  = opened_r ? '0 : rh_mem[sel_r];
  assign wrap = (SUM_BITS'(bcx) + w_s) > aw_s;
  assign ncx  = wrap ? COORD_BITS'(START_POS) : bcx;
  assign ncy  = wrap ? COORD_BITS'(bcy + brh) : bcy;
  assign nrh  = wrap ? '0 : brh;
  assign rh_upd = (h_s > SUM_BITS'(nrh)) ? COORD_BITS'(h_r) : nrh;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      w_r <= in_ch.req_width;
      h_r <= in_ch.req_height;
    end
    if (cmd.open_new) begin
      sel_r    <= pages_open_r[PAGE_BITS-1:0];
      opened_r <= 1'b1;
    end else if (cmd.sel_scan) begin
      sel_r    <= scan_r[PAGE_BITS-1:0];
      opened_r <= 1'b0;
    end
    if (cmd.place) begin
      cx_mem[sel_r] <= COORD_BITS'(ncx + COORD_BITS'(w_r));
      cy_mem[sel_r] <= ncy;
      rh_mem[sel_r] <= rh_upd;
      res_page_r    <= PAGE_IDX_BITS'(sel_r);
      res_x_r       <= FIELD_BITS'(ncx);
      res_y_r       <= FIELD_BITS'(ncy);
      res_opened_r  <= opened_r;
      res_status_r  <= STAT_PLACED;
    end else if (cmd.err_big || cmd.err_full) begin
      res_page_r    <= '0;
      res_x_r       <= '0;
      res_y_r       <= '0;
      res_opened_r  <= 1'b0;
      res_status_r  <= cmd.err_big ? STAT_TOO_BIG : STAT_NO_PAGE;
    end
    if (cmd.out_load) begin
      out_page_r   <= res_page_r;
      out_x_r      <= res_x_r;
      out_y_r      <= res_y_r;
      out_opened_r <= res_opened_r;
      out_status_r <= res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pages_open_r <= '0;
      scan_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.clr_scan) begin
        scan_r <= '0;
      end else if (cmd.inc_scan) begin
        scan_r <= scan_r + 1'b1;
      end
      if (cmd.place && opened_r) begin
        pages_open_r <= pages_open_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.page_index  = out_page_r;
  assign out_ch.pos_x       = out_x_r;
  assign out_ch.pos_y       = out_y_r;
  assign out_ch.opened_page = out_opened_r;
  assign out_ch.status      = out_status_r;

endmodule
`default_nettype wire

>>> rtl/asa_checker.sv
// Port-level checks for the shelf allocator, bound to the top level.
// Depends on asa_pkg.
`default_nettype none
module asa_checker import asa_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic [PAGE_IDX_BITS-1:0] page_index,
  input wire logic [FIELD_BITS-1:0]    pos_x,
  input wire logic [FIELD_BITS-1:0]    pos_y,
  input wire logic                     opened_page,
  input wire logic [1:0]               status
);

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a pending result is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // errors carry zeroed placement fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != STAT_PLACED) |->
      page_index == '0 && pos_x == '0 && pos_y == '0 && !opened_page)
    else $error("error result with placement data");

  // a page is opened only by a successful placement
  a_open_placed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && opened_page |-> status == STAT_PLACED)
    else $error("page opened on error");

  // placed rectangles never sit in row zero or column zero
  a_pos_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == STAT_PLACED) |-> pos_x != '0 && pos_y != '0)
    else $error("placement on page border");

endmodule

bind atlas_shelf_allocator asa_checker u_asa_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .page_index  (out_ch.page_index),
  .pos_x       (out_ch.pos_x),
  .pos_y       (out_ch.pos_y),
  .opened_page (out_ch.opened_page),
  .status      (out_ch.status)
);
`default_nettype wire
